// ----- hw/rtl/lcdb_pkg.sv -----
// Shared constants, types and helper functions for the dual-budget LRU cache.
`default_nettype none
package lcdb_pkg;

    localparam int SLOTS       = 4096;
    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int LINK_W      = SLOT_W + 1;
    localparam logic [LINK_W-1:0] NIL = LINK_W'(SLOTS);
    localparam int BUCKET_BITS = 12;
    localparam int NBUCKETS    = 1 << BUCKET_BITS;
    localparam int FONT_COUNT  = 3;
    localparam int FONT_W      = 3;
    localparam int KEY_W       = 32;
    localparam int WIDTH_W     = 11;
    localparam int HEIGHT_W    = 10;
    localparam int DIMS_W      = WIDTH_W + HEIGHT_W;
    localparam int COUNT_W     = 13;
    localparam int BYTES_W     = 35;
    localparam int BLIM_W      = 29;
    localparam int STAMP_W     = 32;
    localparam int MAX_EVICT   = 62;
    localparam int EVCNT_W     = 6;
    localparam int BIT_W       = 6;
    localparam int BM_W        = 1 << BIT_W;
    localparam int ROW_W       = SLOT_W - BIT_W;
    localparam int BM_ROWS     = 1 << ROW_W;
    localparam int CMD_DEPTH   = 4;
    localparam int RES_DEPTH   = 4;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 29;

    localparam logic [31:0] HASH_GOLD = 32'h9E37_79B9;
    localparam logic [31:0] HASH_MUL  = 32'h85EB_CA6B;
    localparam logic [COUNT_W-1:0] ENTRY_LIMIT_RST = 13'd2000;
    localparam logic [BLIM_W-1:0]  BYTE_LIMIT_RST  = 29'd29360128;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENTRY_LIMIT = 1'b0,
        CFG_BYTE_LIMIT  = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        KIND_HIT    = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_EVICT  = 2'd2,
        KIND_REJECT = 2'd3
    } kind_t;

    typedef struct packed {
        logic                   is_frame;
        logic [KEY_W-1:0]       key;
        logic [FONT_W-1:0]      font;
        logic [WIDTH_W-1:0]     w;
        logic [HEIGHT_W-1:0]    h;
        logic [BUCKET_BITS-1:0] bucket;
    } cmd_t;

    typedef struct packed {
        kind_t               kind;
        logic [KEY_W-1:0]    key;
        logic [FONT_W-1:0]   font;
        logic [SLOT_W-1:0]   slot;
        logic [WIDTH_W-1:0]  width;
        logic [HEIGHT_W-1:0] height;
        logic [COUNT_W-1:0]  live;
        logic [BYTES_W-1:0]  bytes;
        logic                last;
    } result_t;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_LOOK, ST_HEAD, ST_PROBE, ST_CMP,
        ST_HU1, ST_HU2, ST_HU3, ST_HITOUT, ST_MISS, ST_FREE,
        ST_INS1, ST_INS2, ST_SWC, ST_SWR, ST_EVH, ST_EVW,
        ST_EVU, ST_EVB, ST_EVE, ST_FINAL
    } back_state_t;

    function automatic logic [31:0] font_mul(input logic [FONT_W-1:0] f);
        return 32'(32'(f) * HASH_GOLD);
    endfunction

    function automatic logic [BIT_W-1:0] first_zero_bit(input logic [BM_W-1:0] v);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int i = BM_W - 1; i >= 0; i--) begin
            if (!v[i]) r = BIT_W'(i);
        end
        return r;
    endfunction

    function automatic logic [ROW_W-1:0] first_zero_row(input logic [BM_ROWS-1:0] v);
        logic [ROW_W-1:0] r;
        r = '0;
        for (int i = BM_ROWS - 1; i >= 0; i--) begin
            if (!v[i]) r = ROW_W'(i);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/lcdb_front.sv -----
// Front end: accepts requests, maps the font, hashes the key and queues commands.
`default_nettype none
module lcdb_front (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            push,
    output logic                           full,
    input  wire                            action,
    input  wire  [31:0]                    key_id,
    input  wire  [7:0]                     font_index,
    input  wire  [lcdb_pkg::WIDTH_W-1:0]   width_px,
    input  wire  [lcdb_pkg::HEIGHT_W-1:0]  height_px,
    input  wire                            clearing,
    input  wire                            cmd_pop,
    output logic                           cmd_empty,
    output lcdb_pkg::cmd_t                 cmd
);
    import lcdb_pkg::*;

    localparam int PTR_W = $clog2(CMD_DEPTH);
    localparam int CNT_W = $clog2(CMD_DEPTH + 1);

    logic             a_valid_reg;
    cmd_t             a_cmd_reg;
    logic [31:0]      a_xk_reg;
    logic             b_valid_reg;
    cmd_t             b_cmd_reg;
    cmd_t             q_reg [CMD_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W:0]   occupancy;
    logic             accept;
    logic [FONT_W-1:0] font_mapped;
    logic [31:0]      hash_prod;

    assign occupancy   = {1'b0, count_reg} + (CNT_W+1)'(a_valid_reg) + (CNT_W+1)'(b_valid_reg);
    assign full        = clearing || (occupancy >= (CNT_W+1)'(CMD_DEPTH));
    assign accept      = push && !full;
    assign font_mapped = (font_index < 8'(FONT_COUNT)) ? font_index[FONT_W-1:0] : '0;
    assign hash_prod   = 32'(a_xk_reg * HASH_MUL);
    assign cmd_empty   = (count_reg == '0);
    assign cmd         = q_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            count_reg   <= '0;
        end
        else begin
            a_valid_reg <= accept;
            b_valid_reg <= a_valid_reg;
            if (b_valid_reg) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (cmd_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + CNT_W'(b_valid_reg) - CNT_W'(cmd_pop);
        end
    end

    always_ff @(posedge clk) begin
        if (accept) begin
            a_cmd_reg.is_frame <= action;
            a_cmd_reg.key      <= key_id;
            a_cmd_reg.font     <= font_mapped;
            a_cmd_reg.w        <= width_px;
            a_cmd_reg.h        <= height_px;
            a_cmd_reg.bucket   <= '0;
            a_xk_reg           <= key_id ^ font_mul(font_mapped);
        end
        if (a_valid_reg) begin
            b_cmd_reg        <= a_cmd_reg;
            b_cmd_reg.bucket <= hash_prod[31 -: BUCKET_BITS];
        end
        if (b_valid_reg) begin
            q_reg[wr_ptr_reg] <= b_cmd_reg;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/lcdb_res_fifo.sv -----
// Result queue between the back end and the result ports.
`default_nettype none
module lcdb_res_fifo (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 res_push,
    input  lcdb_pkg::result_t   res_in,
    output logic                res_full,
    input  wire                 pop,
    output logic                empty,
    output lcdb_pkg::result_t   res_out
);
    import lcdb_pkg::*;

    localparam int PTR_W = $clog2(RES_DEPTH);
    localparam int CNT_W = $clog2(RES_DEPTH + 1);

    result_t          q_reg [RES_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_pop;

    assign empty    = (count_reg == '0);
    assign res_full = (count_reg == CNT_W'(RES_DEPTH));
    assign res_out  = q_reg[rd_ptr_reg];
    assign do_pop   = pop && !empty;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (res_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + CNT_W'(res_push) - CNT_W'(do_pop);
        end
    end

    always_ff @(posedge clk) begin
        if (res_push) begin
            q_reg[wr_ptr_reg] <= res_in;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/lcdb_back.sv -----
// Back end: hash chains, recency list, slot allocation and the eviction sweep.
`default_nettype none
module lcdb_back (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [lcdb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire  [lcdb_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                             clearing,
    input  wire                              cmd_empty,
    input  lcdb_pkg::cmd_t                   cmd,
    output logic                             cmd_pop,
    input  wire                              res_full,
    output logic                             res_push,
    output lcdb_pkg::result_t                res_in
);
    import lcdb_pkg::*;

    logic [KEY_W-1:0]       key_mem    [SLOTS];
    logic [FONT_W-1:0]      font_mem   [SLOTS];
    logic [DIMS_W-1:0]      dims_mem   [SLOTS];
    logic [STAMP_W-1:0]     stamp_mem  [SLOTS];
    logic [BUCKET_BITS-1:0] bucket_mem [SLOTS];
    logic [LINK_W-1:0]      chain_mem  [SLOTS];
    logic [LINK_W-1:0]      newer_mem  [SLOTS];
    logic [LINK_W-1:0]      older_mem  [SLOTS];
    logic [LINK_W-1:0]      head_mem   [NBUCKETS];
    logic [BM_W-1:0]        bm_mem     [BM_ROWS];

    logic [KEY_W-1:0]       key_rd;
    logic [FONT_W-1:0]      font_rd;
    logic [DIMS_W-1:0]      dims_rd;
    logic [STAMP_W-1:0]     stamp_rd;
    logic [BUCKET_BITS-1:0] bucket_rd;
    logic [LINK_W-1:0]      chain_rd;
    logic [LINK_W-1:0]      newer_rd;
    logic [LINK_W-1:0]      older_rd;
    logic [LINK_W-1:0]      head_rd;
    logic [BM_W-1:0]        bm_rd;

    logic [SLOT_W-1:0]      ent_raddr;
    logic [SLOT_W-1:0]      chain_raddr;
    logic [SLOT_W-1:0]      link_raddr;
    logic [BUCKET_BITS-1:0] head_raddr;
    logic [ROW_W-1:0]       bm_raddr;

    logic                   ent_we;
    logic                   stamp_we;
    logic [SLOT_W-1:0]      stamp_waddr;
    logic                   chain_we;
    logic [SLOT_W-1:0]      chain_waddr;
    logic [LINK_W-1:0]      chain_wdata;
    logic                   newer_we;
    logic [SLOT_W-1:0]      newer_waddr;
    logic [LINK_W-1:0]      newer_wdata;
    logic                   older_we;
    logic [SLOT_W-1:0]      older_waddr;
    logic [LINK_W-1:0]      older_wdata;
    logic                   head_we;
    logic [BUCKET_BITS-1:0] head_waddr;
    logic [LINK_W-1:0]      head_wdata;
    logic                   bm_we;
    logic [ROW_W-1:0]       bm_waddr;
    logic [BM_W-1:0]        bm_wdata;

    back_state_t            state_reg, state_next;
    cmd_t                   cmd_reg, cmd_next;
    logic [SLOT_W-1:0]      p_reg, p_next;
    logic [LINK_W-1:0]      head_reg, head_next;
    logic [SLOT_W-1:0]      s_reg, s_next;
    logic [LINK_W-1:0]      e_reg, e_next;
    logic [LINK_W-1:0]      prev_reg, prev_next;
    logic [SLOT_W-1:0]      walk_reg, walk_next;
    logic [LINK_W-1:0]      n_reg, n_next;
    logic [LINK_W-1:0]      o_reg, o_next;
    logic [KEY_W-1:0]       cur_key_reg, cur_key_next;
    logic [FONT_W-1:0]      cur_font_reg, cur_font_next;
    logic [DIMS_W-1:0]      cur_dims_reg, cur_dims_next;
    logic [BUCKET_BITS-1:0] cur_bucket_reg, cur_bucket_next;
    logic [LINK_W-1:0]      cur_chain_reg, cur_chain_next;
    logic [DIMS_W-1:0]      prod_reg, prod_next;
    logic [ROW_W-1:0]       row_reg, row_next;
    logic [LINK_W-1:0]      newest_reg, newest_next;
    logic [LINK_W-1:0]      oldest_reg, oldest_next;
    logic [COUNT_W-1:0]     live_reg, live_next;
    logic [BYTES_W-1:0]     bytes_reg, bytes_next;
    logic [STAMP_W-1:0]     frame_reg, frame_next;
    logic [EVCNT_W-1:0]     evcnt_reg, evcnt_next;
    logic [BM_ROWS-1:0]     summary_reg, summary_next;
    logic [BM_ROWS-1:0]     row_init_reg, row_init_next;
    result_t                pend_reg, pend_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic [BUCKET_BITS-1:0] clr_cnt_reg, clr_cnt_next;
    logic [COUNT_W-1:0]     elimit_reg;
    logic [BLIM_W-1:0]      blimit_reg;

    logic [BM_W-1:0]        word;
    logic [BIT_W-1:0]       free_bit;
    logic [BM_W-1:0]        word_set;
    logic [BYTES_W-1:0]     prod_bytes;

    assign cfg_ready  = 1'b1;
    assign clearing   = (state_reg == ST_CLEAR);
    assign word       = row_init_reg[row_reg] ? bm_rd : '0;
    assign free_bit   = first_zero_bit(word);
    assign word_set   = word | (BM_W'(1) << free_bit);
    assign prod_bytes = BYTES_W'({prod_reg, 2'b00});

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            elimit_reg <= ENTRY_LIMIT_RST;
            blimit_reg <= BYTE_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready) begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_ENTRY_LIMIT: elimit_reg <= cfg_data[COUNT_W-1:0];
                CFG_BYTE_LIMIT:  blimit_reg <= cfg_data[BLIM_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk) begin
        if (ent_we) begin
            key_mem[s_reg]    <= cmd_reg.key;
            font_mem[s_reg]   <= cmd_reg.font;
            dims_mem[s_reg]   <= {cmd_reg.w, cmd_reg.h};
            bucket_mem[s_reg] <= cmd_reg.bucket;
        end
        if (stamp_we) begin
            stamp_mem[stamp_waddr] <= frame_reg;
        end
        if (chain_we) begin
            chain_mem[chain_waddr] <= chain_wdata;
        end
        if (newer_we) begin
            newer_mem[newer_waddr] <= newer_wdata;
        end
        if (older_we) begin
            older_mem[older_waddr] <= older_wdata;
        end
        if (head_we) begin
            head_mem[head_waddr] <= head_wdata;
        end
        if (bm_we) begin
            bm_mem[bm_waddr] <= bm_wdata;
        end
        key_rd    <= key_mem[ent_raddr];
        font_rd   <= font_mem[ent_raddr];
        dims_rd   <= dims_mem[ent_raddr];
        stamp_rd  <= stamp_mem[link_raddr];
        bucket_rd <= bucket_mem[link_raddr];
        chain_rd  <= chain_mem[chain_raddr];
        newer_rd  <= newer_mem[link_raddr];
        older_rd  <= older_mem[link_raddr];
        head_rd   <= head_mem[head_raddr];
        bm_rd     <= bm_mem[bm_raddr];
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg      <= ST_CLEAR;
            newest_reg     <= NIL;
            oldest_reg     <= NIL;
            live_reg       <= '0;
            bytes_reg      <= '0;
            frame_reg      <= STAMP_W'(1);
            evcnt_reg      <= '0;
            summary_reg    <= '0;
            row_init_reg   <= '0;
            pend_valid_reg <= 1'b0;
            clr_cnt_reg    <= '0;
        end
        else begin
            state_reg      <= state_next;
            newest_reg     <= newest_next;
            oldest_reg     <= oldest_next;
            live_reg       <= live_next;
            bytes_reg      <= bytes_next;
            frame_reg      <= frame_next;
            evcnt_reg      <= evcnt_next;
            summary_reg    <= summary_next;
            row_init_reg   <= row_init_next;
            pend_valid_reg <= pend_valid_next;
            clr_cnt_reg    <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk) begin
        cmd_reg        <= cmd_next;
        p_reg          <= p_next;
        head_reg       <= head_next;
        s_reg          <= s_next;
        e_reg          <= e_next;
        prev_reg       <= prev_next;
        walk_reg       <= walk_next;
        n_reg          <= n_next;
        o_reg          <= o_next;
        cur_key_reg    <= cur_key_next;
        cur_font_reg   <= cur_font_next;
        cur_dims_reg   <= cur_dims_next;
        cur_bucket_reg <= cur_bucket_next;
        cur_chain_reg  <= cur_chain_next;
        prod_reg       <= prod_next;
        row_reg        <= row_next;
        pend_reg       <= pend_next;
    end

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        p_next          = p_reg;
        head_next       = head_reg;
        s_next          = s_reg;
        e_next          = e_reg;
        prev_next       = prev_reg;
        walk_next       = walk_reg;
        n_next          = n_reg;
        o_next          = o_reg;
        cur_key_next    = cur_key_reg;
        cur_font_next   = cur_font_reg;
        cur_dims_next   = cur_dims_reg;
        cur_bucket_next = cur_bucket_reg;
        cur_chain_next  = cur_chain_reg;
        prod_next       = prod_reg;
        row_next        = row_reg;
        newest_next     = newest_reg;
        oldest_next     = oldest_reg;
        live_next       = live_reg;
        bytes_next      = bytes_reg;
        frame_next      = frame_reg;
        evcnt_next      = evcnt_reg;
        summary_next    = summary_reg;
        row_init_next   = row_init_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        clr_cnt_next    = clr_cnt_reg;

        ent_raddr   = p_reg;
        chain_raddr = p_reg;
        link_raddr  = e_reg[SLOT_W-1:0];
        head_raddr  = cmd_reg.bucket;
        bm_raddr    = e_reg[SLOT_W-1:BIT_W];
        ent_we      = 1'b0;
        stamp_we    = 1'b0;
        stamp_waddr = s_reg;
        chain_we    = 1'b0;
        chain_waddr = s_reg;
        chain_wdata = head_reg;
        newer_we    = 1'b0;
        newer_waddr = s_reg;
        newer_wdata = NIL;
        older_we    = 1'b0;
        older_waddr = s_reg;
        older_wdata = newest_reg;
        head_we     = 1'b0;
        head_waddr  = cmd_reg.bucket;
        head_wdata  = LINK_W'(s_reg);
        bm_we       = 1'b0;
        bm_waddr    = row_reg;
        bm_wdata    = word_set;
        cmd_pop     = 1'b0;
        res_push    = 1'b0;
        res_in      = pend_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                head_we      = 1'b1;
                head_waddr   = clr_cnt_reg;
                head_wdata   = NIL;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (!cmd_empty) begin
                    cmd_pop  = 1'b1;
                    cmd_next = cmd;
                    if (cmd.is_frame) begin
                        frame_next = frame_reg + 1'b1;
                    end
                    else begin
                        state_next = ST_LOOK;
                    end
                end
            end
            ST_LOOK: begin
                head_raddr = cmd_reg.bucket;
                prod_next  = DIMS_W'(cmd_reg.w * cmd_reg.h);
                state_next = ST_HEAD;
            end
            ST_HEAD: begin
                head_next = head_rd;
                p_next    = head_rd[SLOT_W-1:0];
                state_next = (head_rd == NIL) ? ST_MISS : ST_PROBE;
            end
            ST_PROBE: begin
                ent_raddr   = p_reg;
                chain_raddr = p_reg;
                state_next  = ST_CMP;
            end
            ST_CMP: begin
                if (key_rd == cmd_reg.key && font_rd == cmd_reg.font) begin
                    stamp_we      = 1'b1;
                    stamp_waddr   = p_reg;
                    cur_dims_next = dims_rd;
                    if (LINK_W'(p_reg) == newest_reg) begin
                        state_next = ST_HITOUT;
                    end
                    else begin
                        link_raddr = p_reg;
                        state_next = ST_HU1;
                    end
                end
                else if (chain_rd == NIL) begin
                    state_next = ST_MISS;
                end
                else begin
                    p_next     = chain_rd[SLOT_W-1:0];
                    state_next = ST_PROBE;
                end
            end
            ST_HU1: begin
                // The hit entry is not the newest, so its newer link is never empty.
                older_we    = 1'b1;
                older_waddr = newer_rd[SLOT_W-1:0];
                older_wdata = older_rd;
                if (older_rd != NIL) begin
                    newer_we    = 1'b1;
                    newer_waddr = older_rd[SLOT_W-1:0];
                    newer_wdata = newer_rd;
                end
                else begin
                    oldest_next = newer_rd;
                end
                state_next = ST_HU2;
            end
            ST_HU2: begin
                older_we    = 1'b1;
                older_waddr = p_reg;
                older_wdata = newest_reg;
                newer_we    = 1'b1;
                newer_waddr = p_reg;
                newer_wdata = NIL;
                state_next  = ST_HU3;
            end
            ST_HU3: begin
                newer_we    = 1'b1;
                newer_waddr = newest_reg[SLOT_W-1:0];
                newer_wdata = LINK_W'(p_reg);
                newest_next = LINK_W'(p_reg);
                state_next  = ST_HITOUT;
            end
            ST_HITOUT: begin
                pend_next.kind   = KIND_HIT;
                pend_next.key    = cmd_reg.key;
                pend_next.font   = cmd_reg.font;
                pend_next.slot   = p_reg;
                pend_next.width  = cur_dims_reg[DIMS_W-1:HEIGHT_W];
                pend_next.height = cur_dims_reg[HEIGHT_W-1:0];
                pend_next.live   = live_reg;
                pend_next.bytes  = bytes_reg;
                pend_next.last   = 1'b0;
                pend_valid_next  = 1'b1;
                state_next       = ST_FINAL;
            end
            ST_MISS: begin
                if (&summary_reg) begin
                    pend_next.kind   = KIND_REJECT;
                    pend_next.key    = cmd_reg.key;
                    pend_next.font   = cmd_reg.font;
                    pend_next.slot   = '0;
                    pend_next.width  = '0;
                    pend_next.height = '0;
                    pend_next.live   = live_reg;
                    pend_next.bytes  = bytes_reg;
                    pend_next.last   = 1'b0;
                    pend_valid_next  = 1'b1;
                    state_next       = ST_FINAL;
                end
                else begin
                    row_next   = first_zero_row(summary_reg);
                    bm_raddr   = first_zero_row(summary_reg);
                    state_next = ST_FREE;
                end
            end
            ST_FREE: begin
                bm_we                  = 1'b1;
                bm_waddr               = row_reg;
                bm_wdata               = word_set;
                row_init_next[row_reg] = 1'b1;
                summary_next[row_reg]  = &word_set;
                s_next                 = {row_reg, free_bit};
                state_next             = ST_INS1;
            end
            ST_INS1: begin
                ent_we      = 1'b1;
                stamp_we    = 1'b1;
                stamp_waddr = s_reg;
                chain_we    = 1'b1;
                chain_waddr = s_reg;
                chain_wdata = head_reg;
                head_we     = 1'b1;
                head_waddr  = cmd_reg.bucket;
                head_wdata  = LINK_W'(s_reg);
                older_we    = 1'b1;
                older_waddr = s_reg;
                older_wdata = newest_reg;
                newer_we    = 1'b1;
                newer_waddr = s_reg;
                newer_wdata = NIL;
                live_next   = live_reg + 1'b1;
                bytes_next  = bytes_reg + prod_bytes;
                state_next  = ST_INS2;
            end
            ST_INS2: begin
                if (newest_reg != NIL) begin
                    newer_we    = 1'b1;
                    newer_waddr = newest_reg[SLOT_W-1:0];
                    newer_wdata = LINK_W'(s_reg);
                end
                newest_next = LINK_W'(s_reg);
                if (oldest_reg == NIL) begin
                    oldest_next = LINK_W'(s_reg);
                    e_next      = LINK_W'(s_reg);
                end
                else begin
                    e_next = oldest_reg;
                end
                pend_next.kind   = KIND_INSERT;
                pend_next.key    = cmd_reg.key;
                pend_next.font   = cmd_reg.font;
                pend_next.slot   = s_reg;
                pend_next.width  = cmd_reg.w;
                pend_next.height = cmd_reg.h;
                pend_next.live   = live_reg;
                pend_next.bytes  = bytes_reg;
                pend_next.last   = 1'b0;
                pend_valid_next  = 1'b1;
                evcnt_next       = '0;
                state_next       = ST_SWC;
            end
            ST_SWC: begin
                if (e_reg != NIL && evcnt_reg < EVCNT_W'(MAX_EVICT) &&
                    (live_reg > elimit_reg || bytes_reg > BYTES_W'(blimit_reg))) begin
                    ent_raddr   = e_reg[SLOT_W-1:0];
                    chain_raddr = e_reg[SLOT_W-1:0];
                    link_raddr  = e_reg[SLOT_W-1:0];
                    state_next  = ST_SWR;
                end
                else begin
                    state_next = ST_FINAL;
                end
            end
            ST_SWR: begin
                prev_next = newer_rd;
                if (stamp_rd == frame_reg) begin
                    e_next     = newer_rd;
                    state_next = ST_SWC;
                end
                else begin
                    cur_key_next    = key_rd;
                    cur_font_next   = font_rd;
                    cur_dims_next   = dims_rd;
                    cur_bucket_next = bucket_rd;
                    cur_chain_next  = chain_rd;
                    n_next          = newer_rd;
                    o_next          = older_rd;
                    prod_next       = DIMS_W'(dims_rd[DIMS_W-1:HEIGHT_W] *
                                              dims_rd[HEIGHT_W-1:0]);
                    head_raddr      = bucket_rd;
                    state_next      = ST_EVH;
                end
            end
            ST_EVH: begin
                if (head_rd == e_reg) begin
                    head_we    = 1'b1;
                    head_waddr = cur_bucket_reg;
                    head_wdata = cur_chain_reg;
                    state_next = ST_EVU;
                end
                else if (head_rd == NIL) begin
                    state_next = ST_EVU;
                end
                else begin
                    walk_next   = head_rd[SLOT_W-1:0];
                    chain_raddr = head_rd[SLOT_W-1:0];
                    state_next  = ST_EVW;
                end
            end
            ST_EVW: begin
                if (chain_rd == e_reg) begin
                    chain_we    = 1'b1;
                    chain_waddr = walk_reg;
                    chain_wdata = cur_chain_reg;
                    state_next  = ST_EVU;
                end
                else if (chain_rd == NIL) begin
                    state_next = ST_EVU;
                end
                else begin
                    walk_next   = chain_rd[SLOT_W-1:0];
                    chain_raddr = chain_rd[SLOT_W-1:0];
                end
            end
            ST_EVU: begin
                if (n_reg != NIL) begin
                    older_we    = 1'b1;
                    older_waddr = n_reg[SLOT_W-1:0];
                    older_wdata = o_reg;
                end
                else begin
                    newest_next = o_reg;
                end
                if (o_reg != NIL) begin
                    newer_we    = 1'b1;
                    newer_waddr = o_reg[SLOT_W-1:0];
                    newer_wdata = n_reg;
                end
                else begin
                    oldest_next = n_reg;
                end
                bytes_next = bytes_reg - prod_bytes;
                if (live_reg != '0) begin
                    live_next = live_reg - 1'b1;
                end
                bm_raddr   = e_reg[SLOT_W-1:BIT_W];
                state_next = ST_EVB;
            end
            ST_EVB: begin
                bm_we    = 1'b1;
                bm_waddr = e_reg[SLOT_W-1:BIT_W];
                bm_wdata = bm_rd & ~(BM_W'(1) << e_reg[BIT_W-1:0]);
                summary_next[e_reg[SLOT_W-1:BIT_W]] = 1'b0;
                state_next = ST_EVE;
            end
            ST_EVE: begin
                if (!res_full) begin
                    res_push         = 1'b1;
                    pend_next.kind   = KIND_EVICT;
                    pend_next.key    = cur_key_reg;
                    pend_next.font   = cur_font_reg;
                    pend_next.slot   = e_reg[SLOT_W-1:0];
                    pend_next.width  = cur_dims_reg[DIMS_W-1:HEIGHT_W];
                    pend_next.height = cur_dims_reg[HEIGHT_W-1:0];
                    pend_next.live   = live_reg;
                    pend_next.bytes  = bytes_reg;
                    pend_next.last   = 1'b0;
                    evcnt_next       = evcnt_reg + 1'b1;
                    e_next           = prev_reg;
                    state_next       = ST_SWC;
                end
            end
            ST_FINAL: begin
                if (!res_full) begin
                    res_push        = 1'b1;
                    res_in.last     = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= COUNT_W'(SLOTS))
        else $error("live entry count exceeds the slot count");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> (state_reg == ST_IDLE && !cmd_empty))
        else $error("command taken outside the idle state");
    a_push_has_pending: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> (pend_valid_reg && !res_full))
        else $error("result pushed without a pending result or into a full queue");
    a_evict_cap: assert property (@(posedge clk) disable iff (!rst_n)
        evcnt_reg <= EVCNT_W'(MAX_EVICT))
        else $error("eviction count passed its cap");
    a_empty_list: assert property (@(posedge clk) disable iff (!rst_n)
        (newest_reg == NIL) |-> (oldest_reg == NIL))
        else $error("recency list ends disagree");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/lru_cache_dual_budget.sv -----
// Top level of the recency-ordered cache with an entry budget and a byte budget.
//
// Requests enter through a queue interface: an item is taken when push is high
// and full is low. Action 0 looks up (key_id, font_index) and inserts it on a
// miss; action 1 advances the frame number and gives no result. Results leave
// through a second queue interface: while empty is low the oldest result is on
// the result ports, and it is taken when pop is high. Every lookup gives one
// hit, insert or reject result; an insert may be followed by up to 62 eviction
// results. The final result of a request carries last.
// A request passes two front pipeline stages and a four-deep command queue. The
// back end takes one command at a time. A hit stamps the entry and, unless it is
// already the newest, moves it to the newest end of the recency list; a miss
// takes a free slot and links it as newest, or is rejected when none is free.
// While a budget is exceeded, the sweep then evicts from the oldest end, passing
// entries stamped in the current frame. The entry and byte limits are written
// through the cfg port, which is always ready; write them only while the block
// is idle. After reset the block clears its 4096 bucket heads, one per cycle,
// and holds full high until the clear is done. When pop is held low, the
// result queue fills and the back end waits; requests then collect in the
// command queue until full.
`default_nettype none
module lru_cache_dual_budget (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              push,
    output logic                             full,
    input  wire                              action,
    input  wire  [31:0]                      key_id,
    input  wire  [7:0]                       font_index,
    input  wire  [lcdb_pkg::WIDTH_W-1:0]     width_px,
    input  wire  [lcdb_pkg::HEIGHT_W-1:0]    height_px,
    output logic                             empty,
    input  wire                              pop,
    output logic [1:0]                       kind,
    output logic [31:0]                      entry_key,
    output logic [lcdb_pkg::FONT_W-1:0]      entry_font,
    output logic [lcdb_pkg::SLOT_W-1:0]      slot,
    output logic [lcdb_pkg::WIDTH_W-1:0]     entry_width,
    output logic [lcdb_pkg::HEIGHT_W-1:0]    entry_height,
    output logic [lcdb_pkg::COUNT_W-1:0]     live_count,
    output logic [lcdb_pkg::BYTES_W-1:0]     byte_count,
    output logic                             last,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [lcdb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire  [lcdb_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import lcdb_pkg::*;

    logic    clearing;
    logic    cmd_empty;
    logic    cmd_pop;
    cmd_t    cmd;
    logic    res_full;
    logic    res_push;
    result_t res_in;
    result_t res_out;

    lcdb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .action     (action),
        .key_id     (key_id),
        .font_index (font_index),
        .width_px   (width_px),
        .height_px  (height_px),
        .clearing   (clearing),
        .cmd_pop    (cmd_pop),
        .cmd_empty  (cmd_empty),
        .cmd        (cmd)
    );

    lcdb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .clearing  (clearing),
        .cmd_empty (cmd_empty),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_in    (res_in)
    );

    lcdb_res_fifo u_res_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_in   (res_in),
        .res_full (res_full),
        .pop      (pop),
        .empty    (empty),
        .res_out  (res_out)
    );

    assign kind         = res_out.kind;
    assign entry_key    = res_out.key;
    assign entry_font   = res_out.font;
    assign slot         = res_out.slot;
    assign entry_width  = res_out.width;
    assign entry_height = res_out.height;
    assign live_count   = res_out.live;
    assign byte_count   = res_out.bytes;
    assign last         = res_out.last;

endmodule
`default_nettype wire
